// File: sv/block_average_label_downsampler_macros.svh
// ---------------------------------------------------------------------------
// Block average label downsampler: assertion macros
// Shorthand for clocked assertions that are disabled during reset.
// ---------------------------------------------------------------------------
`ifndef BLOCK_AVERAGE_LABEL_DOWNSAMPLER_MACROS_SVH
`define BLOCK_AVERAGE_LABEL_DOWNSAMPLER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BALD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BALD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/bald_pkg.sv
// ---------------------------------------------------------------------------
// Block average label downsampler package
// Shared widths, register indexes, reset values and payload types.
// ---------------------------------------------------------------------------
`default_nettype none

package bald_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_RATIO_DEF = 8;

  localparam int PIX_W   = 8;
  localparam int LABEL_W = 8;
  localparam int SUM_W   = 14;
  localparam int MEAN_W  = 16;
  localparam int COL_W   = 10;
  localparam int LW_W    = 11;
  localparam int BR_W    = 4;

  localparam int CFG_AW    = 5;
  localparam int CFG_DW    = 32;
  localparam int OUT_DEPTH = 4;

  localparam logic [LW_W-1:0]    LINE_WIDTH_RST = LW_W'(640);
  localparam logic [BR_W-1:0]    BLOCK_RATIO_RST = BR_W'(2);
  localparam logic [LABEL_W-1:0] FG_CODE_RST = LABEL_W'(1);
  localparam logic [LABEL_W-1:0] CHECK_CODE_RST = LABEL_W'(2);
  localparam logic [LABEL_W-1:0] NOLABEL_CODE_RST = LABEL_W'(3);
  localparam logic [LABEL_W-1:0] BG_CODE_RST = LABEL_W'(0);

  typedef enum logic [2:0] {
    REG_LINE_WIDTH,
    REG_BLOCK_RATIO,
    REG_FG_CODE,
    REG_CHECK_CODE,
    REG_NOLABEL_CODE,
    REG_BG_CODE
  } reg_idx_t;

  typedef struct packed {
    logic               found;
    logic [LABEL_W-1:0] label;
    logic [SUM_W-1:0]   blue;
    logic [SUM_W-1:0]   green;
    logic [SUM_W-1:0]   red;
  } line_entry_t;

  typedef struct packed {
    logic [MEAN_W-1:0]  mean_red;
    logic [MEAN_W-1:0]  mean_green;
    logic [MEAN_W-1:0]  mean_blue;
    logic [LABEL_W-1:0] block_label;
    logic [COL_W-1:0]   block_column;
    logic               row_end;
  } result_t;

endpackage

`default_nettype wire

// File: sv/bald_if.sv
// ---------------------------------------------------------------------------
// Block average label downsampler channel interfaces
// Valid/ready channels for input pixels and for block results.
// ---------------------------------------------------------------------------
`default_nettype none

interface bald_in_if
  import bald_pkg::*;
  ;
  logic               valid;
  logic               ready;
  logic               frame_start;
  logic [PIX_W-1:0]   red;
  logic [PIX_W-1:0]   green;
  logic [PIX_W-1:0]   blue;
  logic [LABEL_W-1:0] pixel_label;

  modport source (output valid, frame_start, red, green, blue, pixel_label, input ready);
  modport sink (input valid, frame_start, red, green, blue, pixel_label, output ready);
endinterface

interface bald_out_if
  import bald_pkg::*;
  ;
  logic               valid;
  logic               ready;
  logic [MEAN_W-1:0]  mean_red;
  logic [MEAN_W-1:0]  mean_green;
  logic [MEAN_W-1:0]  mean_blue;
  logic [LABEL_W-1:0] block_label;
  logic [COL_W-1:0]   block_column;
  logic               row_end;

  modport source (output valid, mean_red, mean_green, mean_blue, block_label, block_column,
                  row_end, input ready);
  modport sink (input valid, mean_red, mean_green, mean_blue, block_label, block_column,
                row_end, output ready);
endinterface

`default_nettype wire

// File: sv/block_average_label_downsampler.sv
// ---------------------------------------------------------------------------
// Block average label downsampler
// Shrinks a raster pixel stream by an integer ratio, averaging color and
// reducing labels over each block through a per-column line store.
// ---------------------------------------------------------------------------
// The block takes one pixel per clock cycle while the input is not stalled,
// including the pixel that completes a block. Each pixel makes one
// read-modify-write pass over the line store entry of its block column: the
// entry is read in the cycle of the transaction and written back in the next,
// with forwarding when two successive pixels hit the same column. A result
// passes the s1 and s2 registers and the output queue before it appears on
// the output. Results wait in a four-entry output queue; the input stalls
// only while four results are owed and not yet taken. The line store needs
// no clearing after reset, so the block is ready once reset ends.
`default_nettype none

module block_average_label_downsampler
  import bald_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int MAX_RATIO = MAX_RATIO_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  bald_in_if.sink                in_chan,
  bald_out_if.source             out_chan,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready
);

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int RW  = $clog2(MAX_RATIO);
  localparam int RBW = $clog2(MAX_RATIO + 1);
  localparam int KW  = WW + RW;
  localparam int MW  = KW + 1;
  localparam int SX  = SUM_W + 8;
  localparam int KA  = SX + 2 * RW;
  localparam int MA  = KA + 1;
  localparam int NPW = WW + MW;
  localparam int PPW = AW + MW;
  localparam int APW = SX + MA;
  localparam int FPW = $clog2(OUT_DEPTH);
  localparam int PNW = $clog2(OUT_DEPTH + 1);

  logic [LW_W-1:0]    line_width_r;
  logic [BR_W-1:0]    block_ratio_r;
  logic [LABEL_W-1:0] fg_code_r;
  logic [LABEL_W-1:0] check_code_r;
  logic [LABEL_W-1:0] nolabel_code_r;
  logic [LABEL_W-1:0] bg_code_r;

  logic [AW-1:0]    pc_r, pc_nxt;
  logic [RW-1:0]    sc_r, sc_nxt;
  logic [RW-1:0]    rb_r, rb_nxt;
  logic [COL_W-1:0] oc_r, oc_nxt;

  logic [MW-1:0] recip_w [0:MAX_RATIO];
  logic [MA-1:0] recip_a [0:MAX_RATIO];

  logic [AW-1:0]    pc;
  logic [RW-1:0]    sc;
  logic [RW-1:0]    rb;
  logic [COL_W-1:0] oc;
  logic [RBW-1:0]   eff_r;
  logic [WW-1:0]    eff_w;
  logic [NPW-1:0]   nb_prod;
  logic [PPW-1:0]   pq_prod;
  logic [WW-1:0]    nb;
  logic [AW-1:0]    pq;
  logic             active;
  logic             sub_last;
  logic             row_last;
  logic             first_px;
  logic             emit;
  logic             row_end0;
  logic             is_cls;
  logic             accept;
  logic             cfg_wr;

  line_entry_t line_mem [0:MAX_WIDTH-1];
  line_entry_t rd_r;
  line_entry_t old_ent;
  line_entry_t wr_ent;

  logic             s1_v_r;
  logic [AW-1:0]    s1_addr_r;
  logic             s1_first_r;
  logic             s1_cls_r;
  logic             s1_emit_r;
  logic             s1_rend_r;
  logic [COL_W-1:0] s1_col_r;
  logic [LABEL_W-1:0] s1_lab_r;
  logic [PIX_W-1:0] s1_red_r;
  logic [PIX_W-1:0] s1_green_r;
  logic [PIX_W-1:0] s1_blue_r;

  logic             fwd_v_r;
  logic [AW-1:0]    fwd_addr_r;
  line_entry_t      fwd_ent_r;

  logic             s2_v_r;
  line_entry_t      s2_ent_r;
  logic [COL_W-1:0] s2_col_r;
  logic             s2_rend_r;
  result_t          s2_res;

  result_t          fifo_mem [0:OUT_DEPTH-1];
  logic [FPW-1:0]   wp_r;
  logic [FPW-1:0]   rp_r;
  logic [PNW-1:0]   cnt_r, cnt_nxt;
  logic [PNW-1:0]   pend_r, pend_nxt;
  logic             pop;
  result_t          head;

  for (genvar g = 0; g <= MAX_RATIO; g++) begin : g_recip
    if (g == 0) begin : g_zero
      assign recip_w[g] = '0;
      assign recip_a[g] = '0;
    end else begin : g_val
      localparam longint unsigned DivW = longint'(g);
      localparam longint unsigned DivA = longint'(g * g);
      localparam longint unsigned RecW = ((64'd1 << KW) + DivW - 64'd1) / DivW;
      localparam longint unsigned RecA = ((64'd1 << KA) + DivA - 64'd1) / DivA;
      assign recip_w[g] = MW'(RecW);
      assign recip_a[g] = MA'(RecA);
    end
  end

  function automatic logic [MEAN_W-1:0] mean_of(input logic [SUM_W-1:0] sum,
                                                input logic [MA-1:0] rec);
    logic [APW-1:0] prod;
    prod = APW'({sum, 8'b0}) * APW'(rec);
    return MEAN_W'(prod >> KA);
  endfunction

  // Configuration port.
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r   <= LINE_WIDTH_RST;
      block_ratio_r  <= BLOCK_RATIO_RST;
      fg_code_r      <= FG_CODE_RST;
      check_code_r   <= CHECK_CODE_RST;
      nolabel_code_r <= NOLABEL_CODE_RST;
      bg_code_r      <= BG_CODE_RST;
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[CFG_AW-1:2]))
        REG_LINE_WIDTH:   line_width_r   <= pwdata[LW_W-1:0];
        REG_BLOCK_RATIO:  block_ratio_r  <= pwdata[BR_W-1:0];
        REG_FG_CODE:      fg_code_r      <= pwdata[LABEL_W-1:0];
        REG_CHECK_CODE:   check_code_r   <= pwdata[LABEL_W-1:0];
        REG_NOLABEL_CODE: nolabel_code_r <= pwdata[LABEL_W-1:0];
        REG_BG_CODE:      bg_code_r      <= pwdata[LABEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[CFG_AW-1:2]))
      REG_LINE_WIDTH:   prdata = CFG_DW'(line_width_r);
      REG_BLOCK_RATIO:  prdata = CFG_DW'(block_ratio_r);
      REG_FG_CODE:      prdata = CFG_DW'(fg_code_r);
      REG_CHECK_CODE:   prdata = CFG_DW'(check_code_r);
      REG_NOLABEL_CODE: prdata = CFG_DW'(nolabel_code_r);
      REG_BG_CODE:      prdata = CFG_DW'(bg_code_r);
      default:          prdata = '0;
    endcase
  end

  // Input stage: counters, block geometry and line store read.
  always_comb begin
    pc = in_chan.frame_start ? '0 : pc_r;
    sc = in_chan.frame_start ? '0 : sc_r;
    rb = in_chan.frame_start ? '0 : rb_r;
    oc = in_chan.frame_start ? '0 : oc_r;

    if (block_ratio_r == '0) begin
      eff_r = RBW'(1);
    end else if (int'(block_ratio_r) > MAX_RATIO) begin
      eff_r = RBW'(MAX_RATIO);
    end else begin
      eff_r = RBW'(block_ratio_r);
    end

    if (line_width_r == '0) begin
      eff_w = WW'(1);
    end else if (int'(line_width_r) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(line_width_r);
    end

    nb_prod = NPW'(eff_w) * NPW'(recip_w[eff_r]);
    pq_prod = PPW'(pc) * PPW'(recip_w[eff_r]);
    nb      = WW'(nb_prod >> KW);
    pq      = AW'(pq_prod >> KW);

    active   = (int'(pq) < int'(nb)) && (int'(oc) < int'(nb)) && (int'(oc) < MAX_WIDTH);
    sub_last = (int'(sc) + 1) >= int'(eff_r);
    row_last = (int'(rb) + 1) >= int'(eff_r);
    first_px = (rb == '0) && (sc == '0);
    emit     = active && sub_last && row_last;
    row_end0 = (int'(oc) + 1) == int'(nb);
    is_cls   = (in_chan.pixel_label == fg_code_r) || (in_chan.pixel_label == check_code_r) ||
               (in_chan.pixel_label == nolabel_code_r);

    if (sub_last) begin
      sc_nxt = '0;
      oc_nxt = oc + COL_W'(1);
    end else begin
      sc_nxt = sc + RW'(1);
      oc_nxt = oc;
    end
    if ((int'(pc) + 1) >= int'(eff_w)) begin
      pc_nxt = '0;
      sc_nxt = '0;
      oc_nxt = '0;
      rb_nxt = row_last ? '0 : rb + RW'(1);
    end else begin
      pc_nxt = pc + AW'(1);
      rb_nxt = rb;
    end
  end

  assign accept        = in_chan.valid && in_chan.ready;
  assign in_chan.ready = pend_r < PNW'(OUT_DEPTH);

  // Read-modify-write stage with forwarding of the write from the same edge.
  always_comb begin
    if (fwd_v_r && (fwd_addr_r == s1_addr_r)) begin
      old_ent = fwd_ent_r;
    end else begin
      old_ent = rd_r;
    end
    if (s1_first_r) begin
      wr_ent.red   = SUM_W'(s1_red_r);
      wr_ent.green = SUM_W'(s1_green_r);
      wr_ent.blue  = SUM_W'(s1_blue_r);
      wr_ent.found = s1_cls_r;
      wr_ent.label = s1_cls_r ? s1_lab_r : '0;
    end else begin
      wr_ent.red   = old_ent.red + SUM_W'(s1_red_r);
      wr_ent.green = old_ent.green + SUM_W'(s1_green_r);
      wr_ent.blue  = old_ent.blue + SUM_W'(s1_blue_r);
      if (!old_ent.found && s1_cls_r) begin
        wr_ent.found = 1'b1;
        wr_ent.label = s1_lab_r;
      end else begin
        wr_ent.found = old_ent.found;
        wr_ent.label = old_ent.label;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_r <= line_mem[AW'(oc)];
    if (s1_v_r) begin
      line_mem[s1_addr_r] <= wr_ent;
    end
  end

  // Mean stage: scaling by the reciprocal of the block area.
  always_comb begin
    s2_res.mean_red     = mean_of(s2_ent_r.red, recip_a[eff_r]);
    s2_res.mean_green   = mean_of(s2_ent_r.green, recip_a[eff_r]);
    s2_res.mean_blue    = mean_of(s2_ent_r.blue, recip_a[eff_r]);
    s2_res.block_label  = s2_ent_r.found ? s2_ent_r.label : bg_code_r;
    s2_res.block_column = s2_col_r;
    s2_res.row_end      = s2_rend_r;
  end

  // Output queue.
  assign pop  = out_chan.valid && out_chan.ready;
  assign head = fifo_mem[rp_r];

  always_comb begin
    cnt_nxt  = cnt_r;
    pend_nxt = pend_r;
    if (s2_v_r) begin
      cnt_nxt = cnt_nxt + PNW'(1);
    end
    if (pop) begin
      cnt_nxt  = cnt_nxt - PNW'(1);
      pend_nxt = pend_nxt - PNW'(1);
    end
    if (accept && emit) begin
      pend_nxt = pend_nxt + PNW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r    <= '0;
      sc_r    <= '0;
      rb_r    <= '0;
      oc_r    <= '0;
      s1_v_r  <= 1'b0;
      fwd_v_r <= 1'b0;
      s2_v_r  <= 1'b0;
      wp_r    <= '0;
      rp_r    <= '0;
      cnt_r   <= '0;
      pend_r  <= '0;
    end else begin
      if (accept) begin
        pc_r <= pc_nxt;
        sc_r <= sc_nxt;
        rb_r <= rb_nxt;
        oc_r <= oc_nxt;
      end
      s1_v_r  <= accept && active;
      fwd_v_r <= s1_v_r;
      s2_v_r  <= s1_v_r && s1_emit_r;
      if (s2_v_r) begin
        wp_r <= wp_r + FPW'(1);
      end
      if (pop) begin
        rp_r <= rp_r + FPW'(1);
      end
      cnt_r  <= cnt_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_addr_r  <= AW'(oc);
    s1_first_r <= first_px;
    s1_cls_r   <= is_cls;
    s1_emit_r  <= emit;
    s1_rend_r  <= row_end0;
    s1_col_r   <= oc;
    s1_lab_r   <= in_chan.pixel_label;
    s1_red_r   <= in_chan.red;
    s1_green_r <= in_chan.green;
    s1_blue_r  <= in_chan.blue;
    fwd_addr_r <= s1_addr_r;
    fwd_ent_r  <= wr_ent;
    s2_ent_r   <= wr_ent;
    s2_col_r   <= s1_col_r;
    s2_rend_r  <= s1_rend_r;
    if (s2_v_r) begin
      fifo_mem[wp_r] <= s2_res;
    end
  end

  assign out_chan.valid        = cnt_r != '0;
  assign out_chan.mean_red     = head.mean_red;
  assign out_chan.mean_green   = head.mean_green;
  assign out_chan.mean_blue    = head.mean_blue;
  assign out_chan.block_label  = head.block_label;
  assign out_chan.block_column = head.block_column;
  assign out_chan.row_end      = head.row_end;

endmodule

`default_nettype wire

// File: sv/bald_checker.sv
// ---------------------------------------------------------------------------
// Block average label downsampler checker
// Port-level assertions on the result channel and the configuration port.
// ---------------------------------------------------------------------------
`default_nettype none

`include "block_average_label_downsampler_macros.svh"

module bald_checker
  import bald_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [MEAN_W-1:0]  mean_red,
  input wire logic [MEAN_W-1:0]  mean_green,
  input wire logic [MEAN_W-1:0]  mean_blue,
  input wire logic [LABEL_W-1:0] block_label,
  input wire logic [COL_W-1:0]   block_column,
  input wire logic               row_end,
  input wire logic               pready
);

  `BALD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "Result dropped while stalled.")
  `BALD_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(mean_red) && $stable(mean_green) && $stable(mean_blue) && $stable(block_label) && $stable(block_column) && $stable(row_end), "Result changed while stalled.")
  `BALD_ASSERT_NOW(a_pready, 1'b1, pready, "Configuration port inserted a wait state.")

endmodule

bind block_average_label_downsampler bald_checker u_bald_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .mean_red     (out_chan.mean_red),
  .mean_green   (out_chan.mean_green),
  .mean_blue    (out_chan.mean_blue),
  .block_label  (out_chan.block_label),
  .block_column (out_chan.block_column),
  .row_end      (out_chan.row_end),
  .pready       (pready)
);

`default_nettype wire
